// File: rtl/etw_pkg.sv
// etw_pkg: shared constants, types and step functions of the edge taper window
// no dependencies; imported by etw_gain, edge_taper_window_2d_top, etw_checker and tb_top
package etw_pkg;

  localparam int HalfW = 11;
  localparam int WinW = 17;
  localparam int CutW = 11;
  localparam int SampleW = 32;
  localparam int GainW = 17;
  localparam int QuotW = 33;

  localparam int DEF_MAX_HALF_ROWS = 1024;
  localparam int DEF_MAX_HALF_COLS = 1024;

  localparam logic [HalfW-1:0] HALF_ROWS_RST = 11'd1024;
  localparam logic [HalfW-1:0] HALF_COLS_RST = 11'd1024;
  localparam logic [WinW-1:0] WINDOW_RST = 17'd16384;

  localparam logic [1:0] REG_HALF_ROWS = 2'd0;
  localparam logic [1:0] REG_HALF_COLS = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  localparam logic [31:0] Q28_ONE = 32'd268435456;
  localparam logic [31:0] COEF3 = 32'd1766234505;
  localparam logic [31:0] COEF5 = 32'd3486407168;
  localparam logic [31:0] COEF7 = 32'd3277091374;
  localparam logic [31:0] COEF9 = 32'd1796866758;

  localparam logic [GainW-1:0] GAIN_ONE = 17'd65536;

  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES = QuotW / DIV_PER_STAGE;
  localparam int GAIN_LAT = DIV_STAGES + 9;
  localparam int PIPE_LAT = GAIN_LAT + 4;

  typedef struct packed {
    logic zero;
    logic apply;
  } band_flags_t;

  typedef struct packed {
    logic [CutW-1:0] rem;
    logic qb;
  } div_step_t;

  function automatic div_step_t div_step(input logic [CutW-1:0] rem, input logic b,
                                         input logic [CutW-1:0] d);
    logic [CutW:0] sh;
    div_step_t res;
    sh = {rem, b};
    if (sh >= {1'b0, d}) begin
      res.rem = CutW'(sh - {1'b0, d});
      res.qb = 1'b1;
    end else begin
      res.rem = sh[CutW-1:0];
      res.qb = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [CutW-1:0] cut_of(input logic [HalfW-1:0] half,
                                             input logic [WinW-1:0] win);
    logic [HalfW+WinW-1:0] p;
    p = {{WinW{1'b0}}, half} * {{HalfW{1'b0}}, win};
    return p[CutW+15:16];
  endfunction

endpackage

// File: rtl/etw_gain.sv
// etw_gain: pipelined taper gain W(k) in Q1.16 for one band
// uses etw_pkg; long division pipeline, then sine polynomial pipeline
module etw_gain import etw_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [CutW-1:0]  k,
  input  logic [CutW-1:0]  cut,
  input  band_flags_t      flags,
  output logic [GainW-1:0] gain
);

  logic [CutW-1:0]  rem_q [DIV_STAGES];
  logic [QuotW-1:0] quo_q [DIV_STAGES];
  logic [CutW-1:0]  cut_q [DIV_STAGES];
  band_flags_t      fl [GAIN_LAT-1];

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [CutW-1:0]  rem_in;
      logic [QuotW-1:0] quo_in;
      logic [CutW-1:0]  d_in;
      logic             b0;
      if (s == 0) begin : g_first
        assign rem_in = {1'b0, k[CutW-1:1]};
        assign quo_in = '0;
        assign d_in = cut;
        assign b0 = k[0];
      end else begin : g_rest
        assign rem_in = rem_q[s-1];
        assign quo_in = quo_q[s-1];
        assign d_in = cut_q[s-1];
        assign b0 = 1'b0;
      end
      logic [CutW-1:0]  rem_next;
      logic [QuotW-1:0] quo_next;
      always_comb begin
        div_step_t st;
        rem_next = rem_in;
        quo_next = quo_in;
        for (int j = 0; j < DIV_PER_STAGE; j++) begin
          st = div_step(rem_next, (j == 0) ? b0 : 1'b0, d_in);
          rem_next = st.rem;
          quo_next = {quo_next[QuotW-2:0], st.qb};
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= rem_next;
          quo_q[s] <= quo_next;
          cut_q[s] <= d_in;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= flags;
      for (int i = 1; i < GAIN_LAT - 1; i++) fl[i] <= fl[i-1];
    end
  end

  // phase folding, then odd polynomial
  logic [QuotW-1:0] xp [7];
  logic             upp [7];
  logic [30:0]      yp [6];
  logic [28:0]      r2p [4];
  logic [31:0]      t_c, t_d, t_e, t_f;
  logic [34:0]      s_g;
  logic [35:0]      f_h;
  logic [GainW-1:0] g_i;

  logic [QuotW-1:0] x_a;
  logic             up_a;
  logic [QuotW-1:0] y_a0;
  logic [QuotW-1:0] y_a;
  logic [61:0]      r2_full;
  logic [60:0]      m_c, m_d, m_e, m_f;
  logic [62:0]      m_g;
  logic [35:0]      f_next;
  logic [35:0]      g_sum;
  logic [GainW-1:0] g_next;

  assign x_a = quo_q[DIV_STAGES-1];
  assign up_a = x_a > 33'h080000000;
  assign y_a0 = up_a ? x_a - 33'h080000000 : x_a;
  assign y_a = (y_a0 > 33'h040000000) ? 33'h080000000 - y_a0 : y_a0;

  assign r2_full = {31'd0, yp[0]} * {31'd0, yp[0]};
  assign m_c = {32'd0, r2p[0]} * {29'd0, COEF9};
  assign m_d = {32'd0, r2p[1]} * {29'd0, t_c};
  assign m_e = {32'd0, r2p[2]} * {29'd0, t_d};
  assign m_f = {32'd0, r2p[3]} * {29'd0, t_e};
  assign m_g = {32'd0, yp[5]} * {31'd0, t_f};

  always_comb begin
    if (upp[6]) begin
      f_next = {3'd0, xp[6]} + {1'b0, s_g};
    end else if ({1'b0, s_g} > {3'd0, xp[6]}) begin
      f_next = '0;
    end else begin
      f_next = {3'd0, xp[6]} - {1'b0, s_g};
    end
  end

  assign g_sum = (f_h + 36'd32768) >> 16;

  always_comb begin
    band_flags_t f;
    f = fl[GAIN_LAT-2];
    if (!f.apply) begin
      g_next = GAIN_ONE;
    end else if (f.zero) begin
      g_next = '0;
    end else if (g_sum > {19'd0, GAIN_ONE}) begin
      g_next = GAIN_ONE;
    end else begin
      g_next = g_sum[GainW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp[0] <= x_a;
      upp[0] <= up_a;
      yp[0] <= y_a[30:0];
      for (int i = 1; i < 7; i++) begin
        xp[i] <= xp[i-1];
        upp[i] <= upp[i-1];
      end
      for (int i = 1; i < 6; i++) yp[i] <= yp[i-1];
      r2p[0] <= r2_full[60:32];
      for (int i = 1; i < 4; i++) r2p[i] <= r2p[i-1];
      t_c <= COEF7 - {3'd0, m_c[60:32]};
      t_d <= COEF5 - {3'd0, m_d[60:32]};
      t_e <= COEF3 - {3'd0, m_e[60:32]};
      t_f <= Q28_ONE - {3'd0, m_f[60:32]};
      s_g <= m_g[62:28];
      f_h <= f_next;
      g_i <= g_next;
    end
  end

  assign gain = g_i;

endmodule

// File: rtl/edge_taper_window_2d_top.sv
// edge_taper_window_2d_top: edge taper of half-spectrum 2D coefficients
// uses etw_pkg and two etw_gain band units
//
// channel | signals                               | transaction
// in      | in_valid in_ready row col sample_*    | one coefficient
// out     | out_valid out_ready result_*          | one tapered coefficient
// cfg     | cfg_valid cfg_ready cfg_index cfg_data| one register write
//
// one coefficient per cycle while the output is not stalled; the pipeline length is set by the
// 33-step pipelined divider and the sine polynomial multiplier chain.
// rst clears the valid line and the registers to their reset values.
// a stalled output freezes the whole pipeline; nothing is lost or repeated.
module edge_taper_window_2d_top import etw_pkg::*; #(
  parameter int MAX_HALF_ROWS = DEF_MAX_HALF_ROWS,
  parameter int MAX_HALF_COLS = DEF_MAX_HALF_COLS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [HalfW-1:0]          row,
  input  logic [HalfW-1:0]          col,
  input  logic signed [SampleW-1:0] sample_re,
  input  logic signed [SampleW-1:0] sample_im,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SampleW-1:0] result_re,
  output logic signed [SampleW-1:0] result_im,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [WinW-1:0]           cfg_data
);

  logic [HalfW-1:0] half_rows, half_cols;
  logic [WinW-1:0]  window_width;
  logic [CutW-1:0]  cut_rows, cut_cols;
  logic [HalfW-1:0] hv;
  logic             en;

  assign cfg_ready = 1'b1;
  assign hv = cfg_data[HalfW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      half_rows <= HALF_ROWS_RST;
      half_cols <= HALF_COLS_RST;
      window_width <= WINDOW_RST;
      cut_rows <= cut_of(HALF_ROWS_RST, WINDOW_RST);
      cut_cols <= cut_of(HALF_COLS_RST, WINDOW_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_ROWS: begin
          if (32'(hv) > MAX_HALF_ROWS) begin
            half_rows <= HalfW'(MAX_HALF_ROWS);
            cut_rows <= cut_of(HalfW'(MAX_HALF_ROWS), window_width);
          end else begin
            half_rows <= hv;
            cut_rows <= cut_of(hv, window_width);
          end
        end
        REG_HALF_COLS: begin
          if (32'(hv) > MAX_HALF_COLS) begin
            half_cols <= HalfW'(MAX_HALF_COLS);
            cut_cols <= cut_of(HalfW'(MAX_HALF_COLS), window_width);
          end else begin
            half_cols <= hv;
            cut_cols <= cut_of(hv, window_width);
          end
        end
        REG_WINDOW: begin
          window_width <= cfg_data;
          cut_rows <= cut_of(half_rows, cfg_data);
          cut_cols <= cut_of(half_cols, cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // band offsets
  logic [HalfW-1:0] kr_next, kc_next;
  band_flags_t      fr_next, fc_next;

  always_comb begin
    if (row <= half_rows) kr_next = half_rows - row;
    else kr_next = HalfW'(row - half_rows - 11'd1);
    fr_next.apply = kr_next <= cut_rows;
    fr_next.zero = cut_rows == '0;
    kc_next = half_cols - col;
    fc_next.apply = (col <= half_cols) && (kc_next <= cut_cols);
    fc_next.zero = cut_cols == '0;
  end

  logic [PIPE_LAT-1:0] vld;
  assign en = !vld[PIPE_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  logic [CutW-1:0]    kr, kc, cr, cc;
  band_flags_t        fr, fc;
  logic [SampleW-1:0] sre [GAIN_LAT+2];
  logic [SampleW-1:0] sim [GAIN_LAT+2];

  always_ff @(posedge clk) begin
    if (en) begin
      kr <= kr_next;
      kc <= kc_next;
      cr <= cut_rows;
      cc <= cut_cols;
      fr <= fr_next;
      fc <= fc_next;
      sre[0] <= sample_re;
      sim[0] <= sample_im;
      for (int i = 1; i < GAIN_LAT + 2; i++) begin
        sre[i] <= sre[i-1];
        sim[i] <= sim[i-1];
      end
    end
  end

  logic [GainW-1:0] gr, gc;

  etw_gain u_gain_row (
    .clk  (clk),
    .en   (en),
    .k    (kr),
    .cut  (cr),
    .flags(fr),
    .gain (gr)
  );

  etw_gain u_gain_col (
    .clk  (clk),
    .en   (en),
    .k    (kc),
    .cut  (cc),
    .flags(fc),
    .gain (gc)
  );

  logic [2*GainW-1:0] gg;
  logic [GainW-1:0]   gain;
  logic signed [49:0] p_re, p_im;
  logic signed [49:0] m_re, m_im;

  assign gg = ({{GainW{1'b0}}, gr} * {{GainW{1'b0}}, gc}) + 34'd32768;
  assign m_re = $signed(sre[GAIN_LAT+1]) * $signed({1'b0, gain});
  assign m_im = $signed(sim[GAIN_LAT+1]) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      gain <= gg[GainW+15:16];
      p_re <= m_re + 50'sd32768;
      p_im <= m_im + 50'sd32768;
      result_re <= p_re[47:16];
      result_im <= p_im[47:16];
    end
  end

  assign out_valid = vld[PIPE_LAT-1];

endmodule

// File: dv/etw_checker.sv
// etw_checker: watches the coefficient, result and register channels of the edge taper
// predicts each tapered coefficient and compares it; depends on etw_pkg
`timescale 1ns / 100ps

module etw_checker import etw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [HalfW-1:0]          row,
  input  logic [HalfW-1:0]          col,
  input  logic signed [SampleW-1:0] sample_re,
  input  logic signed [SampleW-1:0] sample_im,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [SampleW-1:0] result_re,
  input  logic signed [SampleW-1:0] result_im,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [WinW-1:0]           cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } tapered_t;

  tapered_t tapered_q[$];
  logic [10:0] hr, hc;
  logic [16:0] ww;

  function automatic logic [63:0] sine_poly(input logic [63:0] r);
    logic [63:0] r2, t;
    r2 = (r * r) >> 32;
    t = COEF9;
    t = COEF7 - ((r2 * t) >> 32);
    t = COEF5 - ((r2 * t) >> 32);
    t = COEF3 - ((r2 * t) >> 32);
    t = Q28_ONE - ((r2 * t) >> 32);
    return (r * t) >> 28;
  endfunction

  function automatic logic [31:0] band_gain(input logic [31:0] k, input logic [31:0] cut);
    logic [63:0] x, y, s, f, g;
    logic upper;
    if (cut == 0) return 0;
    x = (64'(k) << 32) / cut;
    upper = x > 64'h80000000;
    y = upper ? x - 64'h80000000 : x;
    if (y > 64'h40000000) y = 64'h80000000 - y;
    s = sine_poly(y);
    if (upper) f = x + s;
    else f = (s > x) ? 0 : x - s;
    g = (f + 32768) >> 16;
    if (g > 65536) g = 65536;
    return g[31:0];
  endfunction

  function automatic logic [31:0] scaled(input logic signed [31:0] v, input logic [31:0] gain);
    longint p, q;
    p = longint'(v) * longint'(gain) + 32768;
    q = p >>> 16;
    return q[31:0];
  endfunction

  function automatic tapered_t taper(input logic [10:0] r, input logic [10:0] c,
                                     input logic signed [31:0] re,
                                     input logic signed [31:0] im);
    logic [31:0] cr, cc, gr, gc, k, gain;
    logic [63:0] gp;
    tapered_t t;
    cr = (32'(hr) * 32'(ww)) >> 16;
    cc = (32'(hc) * 32'(ww)) >> 16;
    gr = 65536;
    gc = 65536;
    if (c <= hc) begin
      k = hc - c;
      if (k <= cc) gc = band_gain(k, cc);
    end
    if (r <= hr) k = hr - r;
    else k = r - hr - 1;
    if (k <= cr) gr = band_gain(k, cr);
    gp = (64'(gr) * gc + 32768) >> 16;
    gain = gp[31:0];
    t.re = scaled(re, gain);
    t.im = scaled(im, gain);
    return t;
  endfunction

  assign pending = tapered_q.size();

  always @(posedge clk) begin
    tapered_t e;
    int errs;
    errs = 0;
    if (rst) begin
      hr <= HALF_ROWS_RST;
      hc <= HALF_COLS_RST;
      ww <= WINDOW_RST;
      fail_count <= 0;
      tapered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_ROWS: hr <= (cfg_data[10:0] > 1024) ? 11'd1024 : cfg_data[10:0];
          REG_HALF_COLS: hc <= (cfg_data[10:0] > 1024) ? 11'd1024 : cfg_data[10:0];
          REG_WINDOW: ww <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) tapered_q.push_back(taper(row, col, sample_re, sample_im));
      if (out_valid && out_ready) begin
        if (tapered_q.size() == 0) begin
          $error("unexpected transaction re=%0d im=%0d", result_re, result_im);
          errs = errs + 1;
        end else begin
          e = tapered_q.pop_front();
          if (e.re !== result_re) begin
            $error("result_re expected %0d actual %0d", e.re, result_re);
            errs = errs + 1;
          end
          if (e.im !== result_im) begin
            $error("result_im expected %0d actual %0d", e.im, result_im);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: dv/tb_top.sv
// tb_top: stimulus, register phases and verdict for edge_taper_window_2d_top
// depends on etw_pkg and etw_checker
`timescale 1ns / 100ps

module tb_top;
  import etw_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [HalfW-1:0] row, col;
  logic signed [SampleW-1:0] sample_re, sample_im, result_re, result_im;
  logic [1:0] cfg_index;
  logic [WinW-1:0] cfg_data;
  int fail_count, pending, idle_cycles;
  logic [10:0] cur_hr, cur_hc;
  bit rx_random, rx_hold;

  edge_taper_window_2d_top i_dut (.*);
  etw_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    out_ready = 0;
    @(negedge clk);
    while (1) begin
      if (rx_hold) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        rx_hold = 0;
      end
      if (rx_random && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
    if (idx == REG_HALF_ROWS) cur_hr = (val[10:0] > 1024) ? 11'd1024 : val[10:0];
    if (idx == REG_HALF_COLS) cur_hc = (val[10:0] > 1024) ? 11'd1024 : val[10:0];
  endtask

  task automatic send(input logic [10:0] r, input logic [10:0] c,
                      input logic [31:0] re, input logic [31:0] im, input bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    row <= r;
    col <= c;
    sample_re <= re;
    sample_im <= im;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  // positions near the tapered bands most of the time
  task automatic random_coef(input bit gaps);
    logic [10:0] r, c;
    int m;
    m = $urandom_range(0, 3);
    if (m == 0) r = 11'($urandom_range(0, 2047));
    else if (m == 1) r = 11'(cur_hr - $urandom_range(0, cur_hr));
    else r = 11'(cur_hr + $urandom_range(1, 600));
    c = (m == 3) ? 11'($urandom_range(0, 1024)) : 11'(cur_hc - $urandom_range(0, cur_hc));
    send(r, c, $urandom, $urandom, gaps);
  endtask

  initial begin
    logic [16:0] wins[6];
    logic [10:0] hrs[6], hcs[6];
    rst = 1;
    in_valid = 0;
    cfg_valid = 0;
    row = 0; col = 0; sample_re = 0; sample_im = 0; cfg_index = 0; cfg_data = 0;
    rx_random = 0; rx_hold = 0;
    cur_hr = 1024; cur_hc = 1024;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed at reset settings
    send(0, 0, 32'h7fffffff, 32'h80000000, 0);
    send(11'h7ff, 11'h7ff, 32'h80000000, 32'h7fffffff, 0);
    send(1024, 1024, 32'hffffffff, 32'h1, 0);
    send(1025, 1023, 32'h12345678, 32'hedcba987, 0);
    send(1024 - 256, 1024 - 128, -32'sd3, 32'sd3, 0);
    send(1280, 768, 32'h55555555, 32'haaaaaaaa, 0);
    send(2047, 1024, 32'h80000000, 32'h80000000, 0);
    drain();
    // zero cut, cut equal to half, index above 2, saturation
    write_reg(REG_WINDOW, 0);
    write_reg(REG_HALF_ROWS, 11'h7ff);
    write_reg(REG_HALF_COLS, 11'd5);
    write_reg(2'd3, 17'h1ffff);
    send(1024, 5, 32'h7fffffff, 32'h80000000, 0);
    send(1025, 4, 32'h7fffffff, 32'h1, 0);
    send(1023, 6, -32'sd1, 32'sd1, 0);
    drain();
    write_reg(REG_WINDOW, 17'h1ffff);
    write_reg(REG_HALF_ROWS, 1);
    write_reg(REG_HALF_COLS, 1);
    send(0, 0, 32'h7fffffff, 32'h80000000, 0);
    send(1, 1, 32'h7fffffff, 32'h80000000, 0);
    send(2, 2, 32'h7fffffff, 32'h80000000, 0);
    send(2047, 1024, 32'h7fffffff, 32'h80000000, 0);
    drain();

    wins = '{17'd65536, 17'd1, 17'd40000, 17'd16384, 17'd131071, 17'd0};
    hrs = '{11'd1024, 11'd1, 11'd300, 11'd1000, 11'd17, 11'd64};
    hcs = '{11'd1024, 11'd2, 11'd513, 11'd7, 11'd1024, 11'd100};
    rx_random = 1;
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_HALF_ROWS, {6'd0, hrs[p]});
      write_reg(REG_HALF_COLS, {6'd0, hcs[p]});
      write_reg(REG_WINDOW, wins[p]);
      if (p == 2) rx_hold = 1;
      for (int i = 0; i < 70; i++) random_coef(p != 2);
      drain();
    end
    // last part with no idling on either side
    rx_random = 0;
    write_reg(REG_WINDOW, 17'($urandom_range(0, 65536)));
    for (int i = 0; i < 60; i++) random_coef(0);
    drain();

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
